@@ design/rebq_pkg.sv @@
// shared types and constants for the rotary encoder and button qualifier
// no dependencies
package rebq_pkg;

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 16;
  localparam int unsigned POS_W = 16;
  localparam int unsigned TIME_W = 32;

  // register indexes on the configuration port
  localparam logic [CFG_AW-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_LOCKOUT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ROT_TIMEOUT = 2'd2;

  localparam logic [CFG_DW-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [CFG_DW-1:0] LOCKOUT_RST = 16'd250;
  localparam logic [CFG_DW-1:0] ROT_TIMEOUT_RST = 16'd150;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESSED,
    PH_HELD,
    PH_RELEASED
  } phase_t;

  typedef struct packed {
    logic              clk_level;
    logic              dt_level;
    logic              button_level;
    logic [TIME_W-1:0] now_ms;
    logic              take_delta;
    logic              take_click;
  } sample_t;

  typedef struct packed {
    logic [CFG_DW-1:0] debounce_ms;
    logic [CFG_DW-1:0] lockout_ms;
    logic [CFG_DW-1:0] rotation_timeout_ms;
  } cfg_t;

endpackage

@@ design/rebq_enc.sv @@
// quadrature decode, position and reference tracking, rotation activity
// depends on rebq_pkg
module rebq_enc (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  rebq_pkg::sample_t                smp,
  input  rebq_pkg::cfg_t                   cfg,
  output logic signed [rebq_pkg::POS_W-1:0] delta,
  output logic                             rotating
);
  import rebq_pkg::*;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  ref_r, ref_nxt;
  logic              prev_clk_r, prev_clk_nxt;
  logic              prev_dt_r, prev_dt_nxt;
  logic              rot_r, rot_nxt;
  logic [TIME_W-1:0] last_rot_r, last_rot_nxt;
  logic [POS_W-1:0]  diff;
  logic [TIME_W-1:0] quiet;
  logic              clk_edge;

  assign clk_edge = smp.clk_level != prev_clk_r;
  assign quiet    = smp.now_ms - last_rot_r;

  always_comb begin
    pos_nxt      = pos_r;
    prev_clk_nxt = prev_clk_r;
    prev_dt_nxt  = prev_dt_r;
    if (clk_edge) begin
      if (smp.clk_level) begin
        if (!smp.dt_level && prev_dt_r) begin
          pos_nxt = pos_r + 1'b1;
        end else if (smp.dt_level && !prev_dt_r) begin
          pos_nxt = pos_r - 1'b1;
        end
      end
      prev_clk_nxt = smp.clk_level;
      prev_dt_nxt  = smp.dt_level;
    end

    diff         = pos_nxt - ref_r;
    rot_nxt      = rot_r;
    last_rot_nxt = last_rot_r;
    if (diff != '0) begin
      rot_nxt      = 1'b1;
      last_rot_nxt = smp.now_ms;
    end else if (rot_r && (quiet > {{(TIME_W-CFG_DW){1'b0}}, cfg.rotation_timeout_ms})) begin
      rot_nxt = 1'b0;
    end

    // reading the delta moves the reference up to the position
    if (smp.take_delta) begin
      delta   = diff;
      ref_nxt = pos_nxt;
    end else begin
      delta   = '0;
      ref_nxt = ref_r;
    end
    rotating = rot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      ref_r      <= '0;
      prev_clk_r <= 1'b1;
      prev_dt_r  <= 1'b1;
      rot_r      <= 1'b0;
      last_rot_r <= '0;
    end else if (adv) begin
      pos_r      <= pos_nxt;
      ref_r      <= ref_nxt;
      prev_clk_r <= prev_clk_nxt;
      prev_dt_r  <= prev_dt_nxt;
      rot_r      <= rot_nxt;
      last_rot_r <= last_rot_nxt;
    end
  end

endmodule

@@ design/rebq_btn.sv @@
// button debounce machine with click lockout, rotation inhibit and read-and-clear click flag
// depends on rebq_pkg
module rebq_btn (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  rebq_pkg::sample_t smp,
  input  rebq_pkg::cfg_t    cfg,
  input  logic              rotating,
  output logic              click
);
  import rebq_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic              last_pressed_r;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0] last_click_r, last_click_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_now;
  logic              pressed;
  logic              settled;
  logic              past_lockout;

  assign pressed      = !smp.button_level;
  assign settled      = (smp.now_ms - start_r) >= {{(TIME_W-CFG_DW){1'b0}}, cfg.debounce_ms};
  assign past_lockout = (smp.now_ms - last_click_r) >= {{(TIME_W-CFG_DW){1'b0}}, cfg.lockout_ms};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (adv) begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    start_nxt      = start_r;
    last_click_nxt = last_click_r;
    pend_now       = pend_r;
    case (phase_r)
      PH_IDLE: begin
        if (pressed && !last_pressed_r) begin
          phase_nxt = PH_PRESSED;
          start_nxt = smp.now_ms;
        end
      end
      PH_PRESSED: begin
        if (!pressed) begin
          phase_nxt = PH_IDLE;
        end else if (settled) begin
          phase_nxt = PH_HELD;
        end
      end
      PH_HELD: begin
        if (!pressed) begin
          phase_nxt = PH_RELEASED;
          start_nxt = smp.now_ms;
        end
      end
      PH_RELEASED: begin
        if (pressed) begin
          phase_nxt = PH_HELD;
        end else if (settled) begin
          // refused clicks fall back to idle with no new timestamp
          if (past_lockout && !rotating) begin
            pend_now       = 1'b1;
            last_click_nxt = smp.now_ms;
          end
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    // a click latched in this item can be read by the same item
    click    = smp.take_click & pend_now;
    pend_nxt = smp.take_click ? 1'b0 : pend_now;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pressed_r <= 1'b0;
      start_r        <= '0;
      last_click_r   <= '0;
      pend_r         <= 1'b0;
    end else if (adv) begin
      last_pressed_r <= pressed;
      start_r        <= start_nxt;
      last_click_r   <= last_click_nxt;
      pend_r         <= pend_nxt;
    end
  end

endmodule

@@ design/rotary_encoder_button_qualifier.sv @@
// top level: input register, encoder and button logic, result register
// path: an accepted item goes to the input register, its result to the result register
// throughput: one item per cycle; the result register stalls only on out_stall
// while a result waits, one more item is held in the input register
// synchronous active-low reset clears pipeline valids and state, loads config defaults
module rotary_encoder_button_qualifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_clk_level,
  input  logic                             in_dt_level,
  input  logic                             in_button_level,
  input  logic [rebq_pkg::TIME_W-1:0]      in_now_ms,
  input  logic                             in_take_delta,
  input  logic                             in_take_click,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rebq_pkg::POS_W-1:0] out_delta,
  output logic                             out_click,
  output logic                             out_rotating,
  input  logic                             cfg_we,
  input  logic [rebq_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [rebq_pkg::CFG_DW-1:0]      cfg_wdata
);
  import rebq_pkg::*;

  cfg_t                    cfg_r;
  sample_t                 smp_r;
  logic                    in_valid_r;
  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_delta_r;
  logic                    out_click_r;
  logic                    out_rot_r;
  logic                    adv;
  logic signed [POS_W-1:0] delta;
  logic                    rotating;
  logic                    click;

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms         <= DEBOUNCE_RST;
      cfg_r.lockout_ms          <= LOCKOUT_RST;
      cfg_r.rotation_timeout_ms <= ROT_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DEBOUNCE:    cfg_r.debounce_ms         <= cfg_wdata;
        REG_LOCKOUT:     cfg_r.lockout_ms          <= cfg_wdata;
        REG_ROT_TIMEOUT: cfg_r.rotation_timeout_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      smp_r.clk_level    <= in_clk_level;
      smp_r.dt_level     <= in_dt_level;
      smp_r.button_level <= in_button_level;
      smp_r.now_ms       <= in_now_ms;
      smp_r.take_delta   <= in_take_delta;
      smp_r.take_click   <= in_take_click;
    end
  end

  rebq_enc u_enc (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .smp      (smp_r),
    .cfg      (cfg_r),
    .delta    (delta),
    .rotating (rotating)
  );

  rebq_btn u_btn (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .smp      (smp_r),
    .cfg      (cfg_r),
    .rotating (rotating),
    .click    (click)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_delta_r <= delta;
      out_click_r <= click;
      out_rot_r   <= rotating;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_delta    = out_delta_r;
  assign out_click    = out_click_r;
  assign out_rotating = out_rot_r;

endmodule

@@ design/rebq_chk.sv @@
// port-level checks for the rotary encoder and button qualifier
// depends on rebq_pkg; bound to the top level below
module rebq_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [rebq_pkg::POS_W-1:0] out_delta,
  input logic                             out_click,
  input logic                             out_rotating
);
  import rebq_pkg::*;

  // input only backs up when a result is waiting and held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // a nonzero delta read means the sample saw motion
  a_delta_rot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_delta != '0)) |-> out_rotating)
    else $error("nonzero delta while not rotating");

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_delta) && $stable(out_click) && $stable(out_rotating)))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rotary_encoder_button_qualifier rebq_chk u_rebq_chk (.*);

@@ tb/tb_top.sv @@
// self-checking testbench for rotary_encoder_button_qualifier: directed polls and
// random quadrature and button streams under several register settings
// depends on rebq_pkg and the rotary_encoder_button_qualifier rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rebq_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] delta;
    logic             click;
    logic             rotating;
  } qual_result_t;

  typedef struct packed {
    sample_t      s;
    logic         known;
    qual_result_t res;
  } poll_row_t;

  localparam logic KNOWN = 1'b1;
  localparam logic PREDICTED = 1'b0;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_clk_level;
  logic                in_dt_level;
  logic                in_button_level;
  logic [TIME_W-1:0]   in_now_ms;
  logic                in_take_delta;
  logic                in_take_click;
  logic                out_valid;
  logic                out_stall;
  logic signed [POS_W-1:0] out_delta;
  logic                out_click;
  logic                out_rotating;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [CFG_DW-1:0]   cfg_wdata;

  rotary_encoder_button_qualifier dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_clk_level    (in_clk_level),
    .in_dt_level     (in_dt_level),
    .in_button_level (in_button_level),
    .in_now_ms       (in_now_ms),
    .in_take_delta   (in_take_delta),
    .in_take_click   (in_take_click),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_delta       (out_delta),
    .out_click       (out_click),
    .out_rotating    (out_rotating),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata)
  );

  // predictor state
  logic [POS_W-1:0]  enc_position;
  logic [POS_W-1:0]  enc_reference;
  logic              enc_prev_clk;
  logic              enc_prev_dt;
  phase_t            btn_phase;
  logic              btn_was_pressed;
  logic [TIME_W-1:0] btn_phase_start;
  logic [TIME_W-1:0] click_last_ms;
  logic              click_latched;
  logic              rot_active;
  logic [TIME_W-1:0] rot_last_ms;
  logic [CFG_DW-1:0] set_debounce;
  logic [CFG_DW-1:0] set_lockout;
  logic [CFG_DW-1:0] set_rot_timeout;

  qual_result_t awaited_results[$];
  qual_result_t want;
  int           n_polls;
  int           n_results;
  int           n_errors;
  logic         quiet;
  logic         hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  function automatic sample_t poll(input logic c, input logic d, input logic b,
                                   input logic [TIME_W-1:0] t, input logic td,
                                   input logic tc);
    sample_t s;
    s.clk_level = c;
    s.dt_level = d;
    s.button_level = b;
    s.now_ms = t;
    s.take_delta = td;
    s.take_click = tc;
    return s;
  endfunction

  function automatic qual_result_t qualify_poll(input sample_t s);
    qual_result_t r;
    logic pressed;
    logic [POS_W-1:0] unread;
    r = '0;
    pressed = ~s.button_level;
    if (s.clk_level != enc_prev_clk) begin
      if (s.clk_level) begin
        if (!s.dt_level && enc_prev_dt) enc_position = enc_position + 16'd1;
        else if (s.dt_level && !enc_prev_dt) enc_position = enc_position - 16'd1;
      end
      enc_prev_clk = s.clk_level;
      enc_prev_dt = s.dt_level;
    end
    unread = enc_position - enc_reference;
    if (unread != '0) begin
      rot_active = 1'b1;
      rot_last_ms = s.now_ms;
    end else if (rot_active && (s.now_ms - rot_last_ms) > {16'd0, set_rot_timeout}) begin
      rot_active = 1'b0;
    end
    case (btn_phase)
      PH_IDLE: begin
        if (pressed && !btn_was_pressed) begin
          btn_phase = PH_PRESSED;
          btn_phase_start = s.now_ms;
        end
      end
      PH_PRESSED: begin
        if (!pressed) btn_phase = PH_IDLE;
        else if ((s.now_ms - btn_phase_start) >= {16'd0, set_debounce}) btn_phase = PH_HELD;
      end
      PH_HELD: begin
        if (!pressed) begin
          btn_phase = PH_RELEASED;
          btn_phase_start = s.now_ms;
        end
      end
      default: begin
        if (pressed) begin
          btn_phase = PH_HELD;
        end else if ((s.now_ms - btn_phase_start) >= {16'd0, set_debounce}) begin
          // refused clicks still go back to idle
          if ((s.now_ms - click_last_ms) >= {16'd0, set_lockout} && !rot_active) begin
            click_latched = 1'b1;
            click_last_ms = s.now_ms;
          end
          btn_phase = PH_IDLE;
        end
      end
    endcase
    btn_was_pressed = pressed;
    if (s.take_delta) begin
      r.delta = enc_position - enc_reference;
      enc_reference = enc_position;
    end
    if (s.take_click) begin
      r.click = click_latched;
      click_latched = 1'b0;
    end
    r.rotating = rot_active;
    return r;
  endfunction

  // offer one item until accepted, then queue what it should produce
  task automatic feed_poll(input sample_t s, input logic known, input qual_result_t res);
    qual_result_t pred;
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_clk_level <= s.clk_level;
    in_dt_level <= s.dt_level;
    in_button_level <= s.button_level;
    in_now_ms <= s.now_ms;
    in_take_delta <= s.take_delta;
    in_take_click <= s.take_click;
    do @(posedge clk); while (in_stall);
    pred = qualify_poll(s);
    awaited_results.push_back(known ? res : pred);
    n_polls++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  task automatic apply_settings(input logic [CFG_DW-1:0] d, input logic [CFG_DW-1:0] l,
                                input logic [CFG_DW-1:0] r);
    cfg_we <= 1'b1;
    cfg_addr <= REG_DEBOUNCE;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_addr <= REG_LOCKOUT;
    cfg_wdata <= l;
    @(posedge clk);
    cfg_addr <= REG_ROT_TIMEOUT;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    set_debounce = d;
    set_lockout = l;
    set_rot_timeout = r;
  endtask

  // receiver: random stalls, a quiet mode, and one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (64) @(posedge clk);
      end else begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 10);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with no item pending: delta %0d click %0b rotating %0b",
                 $time, out_delta, out_click, out_rotating);
        n_errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_delta !== want.delta) begin
          $display("%0t: delta expected %0d got %0d", $time, $signed(want.delta), out_delta);
          n_errors++;
        end
        if (out_click !== want.click) begin
          $display("%0t: click expected %0b got %0b", $time, want.click, out_click);
          n_errors++;
        end
        if (out_rotating !== want.rotating) begin
          $display("%0t: rotating expected %0b got %0b", $time, want.rotating, out_rotating);
          n_errors++;
        end
      end
    end
  end

  initial begin
    poll_row_t         opening_rows [25];
    logic [1:0]        quad_seq [4];
    sample_t           s;
    logic [1:0]        enc_idx;
    logic              enc_dir;
    logic              enc_busy;
    logic              btn_lvl;
    logic [TIME_W-1:0] now_cur;
    logic [CFG_DW-1:0] d;
    logic [CFG_DW-1:0] l;
    logic [CFG_DW-1:0] r;
    int                step_max;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_clk_level = 1'b1;
    in_dt_level = 1'b1;
    in_button_level = 1'b1;
    in_now_ms = '0;
    in_take_delta = 1'b0;
    in_take_click = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_DEBOUNCE;
    cfg_wdata = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    n_polls = 0;
    n_results = 0;
    n_errors = 0;

    enc_position = '0;
    enc_reference = '0;
    enc_prev_clk = 1'b1;
    enc_prev_dt = 1'b1;
    btn_phase = PH_IDLE;
    btn_was_pressed = 1'b0;
    btn_phase_start = '0;
    click_last_ms = '0;
    click_latched = 1'b0;
    rot_active = 1'b0;
    rot_last_ms = '0;
    set_debounce = DEBOUNCE_RST;
    set_lockout = LOCKOUT_RST;
    set_rot_timeout = ROT_TIMEOUT_RST;

    // gray order 11 01 00 10 counts up going forward
    quad_seq = '{2'b11, 2'b01, 2'b00, 2'b10};

    // encoder: falling edge, up, down, clock edge with no data change, wrap below zero
    opening_rows[0]  = '{poll(1'b1, 1'b1, 1'b1, 32'd0, 1'b1, 1'b1), KNOWN,
                         '{16'd0, 1'b0, 1'b0}};
    opening_rows[1]  = '{poll(1'b0, 1'b1, 1'b1, 32'd1, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[2]  = '{poll(1'b1, 1'b0, 1'b1, 32'd2, 1'b0, 1'b0), KNOWN,
                         '{16'd0, 1'b0, 1'b1}};
    opening_rows[3]  = '{poll(1'b0, 1'b0, 1'b1, 32'd3, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[4]  = '{poll(1'b1, 1'b1, 1'b1, 32'd4, 1'b1, 1'b0), PREDICTED, '0};
    opening_rows[5]  = '{poll(1'b0, 1'b1, 1'b1, 32'd5, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[6]  = '{poll(1'b1, 1'b1, 1'b1, 32'd6, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[7]  = '{poll(1'b0, 1'b0, 1'b1, 32'd7, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[8]  = '{poll(1'b1, 1'b1, 1'b1, 32'd8, 1'b1, 1'b0), KNOWN,
                         '{16'hFFFF, 1'b0, 1'b1}};
    // button: press bounce, release bounce, accepted click
    opening_rows[9]  = '{poll(1'b1, 1'b1, 1'b0, 32'd1000, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[10] = '{poll(1'b1, 1'b1, 1'b1, 32'd1005, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[11] = '{poll(1'b1, 1'b1, 1'b0, 32'd1010, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[12] = '{poll(1'b1, 1'b1, 1'b0, 32'd1040, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[13] = '{poll(1'b1, 1'b1, 1'b1, 32'd1050, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[14] = '{poll(1'b1, 1'b1, 1'b0, 32'd1055, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[15] = '{poll(1'b1, 1'b1, 1'b1, 32'd1060, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[16] = '{poll(1'b1, 1'b1, 1'b1, 32'd1090, 1'b0, 1'b1), KNOWN,
                         '{16'd0, 1'b1, 1'b0}};
    // click refused inside the lockout
    opening_rows[17] = '{poll(1'b1, 1'b1, 1'b0, 32'd1100, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[18] = '{poll(1'b1, 1'b1, 1'b0, 32'd1130, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[19] = '{poll(1'b1, 1'b1, 1'b1, 32'd1140, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[20] = '{poll(1'b1, 1'b1, 1'b1, 32'd1170, 1'b0, 1'b1), KNOWN,
                         '{16'd0, 1'b0, 1'b0}};
    // click refused while rotating
    opening_rows[21] = '{poll(1'b0, 1'b1, 1'b0, 32'd2000, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[22] = '{poll(1'b1, 1'b0, 1'b0, 32'd2040, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[23] = '{poll(1'b1, 1'b0, 1'b1, 32'd2050, 1'b0, 1'b0), PREDICTED, '0};
    opening_rows[24] = '{poll(1'b1, 1'b0, 1'b1, 32'd2080, 1'b1, 1'b1), KNOWN,
                         '{16'd1, 1'b0, 1'b1}};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i])
      feed_poll(opening_rows[i].s, opening_rows[i].known, opening_rows[i].res);

    enc_idx = 2'd0;
    enc_dir = 1'b1;
    enc_busy = 1'b0;
    btn_lvl = 1'b1;
    now_cur = 32'd3000;

    for (int p = 0; p < 7; p++) begin
      drain_results();
      quiet = (p == 4);
      d = DEBOUNCE_RST;
      l = LOCKOUT_RST;
      r = ROT_TIMEOUT_RST;
      step_max = 12;
      case (p)
        1: begin
          d = '0;
          l = '0;
          r = '0;
          step_max = 3;
        end
        2: begin
          d = '1;
          l = '1;
          r = '1;
          step_max = 20000;
          now_cur = $urandom;
        end
        3: begin
          d = 16'd5;
          l = 16'd40;
          r = 16'd20;
          step_max = 6;
          hold_req = 1'b1;
        end
        4: begin
          d = 16'($urandom_range(0, 60));
          l = 16'($urandom_range(0, 400));
          r = 16'($urandom_range(0, 200));
          step_max = 15;
        end
        5: now_cur = 32'hFFFF_FF00;
        6: begin
          d = 16'($urandom_range(0, 65535));
          l = 16'($urandom_range(0, 65535));
          r = 16'($urandom_range(0, 65535));
          step_max = $urandom_range(1, 70000);
        end
        default: ;
      endcase
      if (p != 0) apply_settings(d, l, r);

      repeat (150) begin
        now_cur = now_cur + 32'($urandom_range(0, step_max));
        // rotation comes in bursts so that clicks can get through between them
        if ($urandom_range(19) == 0) enc_busy = ~enc_busy;
        if (enc_busy && $urandom_range(1) == 1) begin
          if ($urandom_range(9) == 0) enc_dir = ~enc_dir;
          enc_idx = enc_dir ? enc_idx + 2'd1 : enc_idx - 2'd1;
        end
        if ($urandom_range(5) == 0) btn_lvl = ~btn_lvl;
        s.clk_level = quad_seq[enc_idx][1];
        s.dt_level = quad_seq[enc_idx][0];
        s.button_level = btn_lvl;
        s.now_ms = ($urandom_range(29) == 0) ? 32'($urandom) : now_cur;
        if ($urandom_range(29) == 0) {s.clk_level, s.dt_level} = 2'($urandom_range(3));
        s.take_delta = ($urandom_range(3) == 0);
        s.take_click = ($urandom_range(2) == 0);
        feed_poll(s, PREDICTED, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("polls sent %0d, results checked %0d, mismatches %0d", n_polls, n_results,
             n_errors);
    $display("covered 7 register settings, time wrap, bounces, refused clicks, delta wrap");
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/rebq_pkg.sv
design/rebq_enc.sv
design/rebq_btn.sv
design/rotary_encoder_button_qualifier.sv
design/rebq_chk.sv
tb/tb_top.sv
